@@ sv/psra_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package psra_pkg;

  // Field widths
  localparam int unsigned SLOT_IN_W  = 10;
  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned LEVEL_W    = 26;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned FILL_W     = 7;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  // Default sizes
  localparam int unsigned SLOTS_DEF        = 1024;
  localparam int unsigned WINDOW_DEPTH_DEF = 64;

  // Milliseconds per second, milli-tokens per token
  localparam int unsigned MS_PER_S = 1000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BURST   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REFILL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_REQ = 2'd3;

  // Register reset values
  localparam logic [15:0] BURST_RST   = 16'd10;
  localparam logic [15:0] REFILL_RST  = 16'd5;
  localparam logic [11:0] WINDOW_RST  = 12'd60;
  localparam logic [6:0]  MAX_REQ_RST = 7'd60;

endpackage

`default_nettype wire

@@ sv/per_source_rate_admission_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel | Signals                                   | Direction
// in      | in_valid_i/in_ready_o, flow_slot_i, now_ms_i | request in
// out     | out_valid_o/out_ready_i, verdict_o, window_fill_o,
//         | total_count_o, allowed_count_o, throttled_count_o | verdict out
// cfg     | cfg_we_i, cfg_addr_i, cfg_wdata_i         | register write
//
// A request that finds a token reads and compares each stamp held in its slot
// window in turn: one read and one compare per stamp on the single stamp memory
// port. A request that finds the bucket empty skips the window. A slot count
// of 1, or one below 1024 that is not a power of two, adds a step for the
// reciprocal reduction of the slot.
// After reset a clearing pass writes each slot in turn and marks it unused;
// no request is taken meanwhile. A result waits in the output register,
// and a following result holds in its last step until that one is taken.

module per_source_rate_admission_unit #(
  parameter int unsigned SLOTS        = psra_pkg::SLOTS_DEF,
  parameter int unsigned WINDOW_DEPTH = psra_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [psra_pkg::SLOT_IN_W-1:0]      flow_slot_i,
  input  wire logic [psra_pkg::STAMP_W-1:0]        now_ms_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                                     verdict_o,
  output logic [psra_pkg::FILL_W-1:0]              window_fill_o,
  output logic [psra_pkg::CNT_W-1:0]               total_count_o,
  output logic [psra_pkg::CNT_W-1:0]               allowed_count_o,
  output logic [psra_pkg::CNT_W-1:0]               throttled_count_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [psra_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input  wire logic [psra_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int unsigned SLOT_W   = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam int unsigned HEAD_W   = WINDOW_DEPTH > 1 ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned OCC_W    = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W    = OCC_W + 1;
  localparam int unsigned ST_DEPTH = SLOTS * WINDOW_DEPTH;
  localparam int unsigned ST_AW    = ST_DEPTH > 1 ? $clog2(ST_DEPTH) : 1;
  localparam int unsigned LVL_W    = psra_pkg::LEVEL_W;
  localparam int unsigned TS_W     = psra_pkg::STAMP_W;
  localparam int unsigned PROD_W   = TS_W + 16;
  localparam int unsigned MOD_SHIFT = 20;
  localparam int unsigned MOD_RECIP = ((1 << MOD_SHIFT) + SLOTS - 1) / SLOTS;
  localparam bit MOD_SERIAL = (SLOTS == 1) ||
                              ((SLOTS < 1024) && ((SLOTS & (SLOTS - 1)) != 0));

  typedef struct packed {
    logic              valid;
    logic [LVL_W-1:0]  level;
    logic [TS_W-1:0]   last;
    logic [HEAD_W-1:0] head;
    logic [OCC_W-1:0]  occ;
  } slot_rec_t;

  localparam int unsigned REC_W = $bits(slot_rec_t);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_MOD, S_RD, S_MUL, S_BKT, S_WRD, S_WCHK, S_WADD, S_DONE
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [15:0] burst_q, refill_q;
  logic [11:0] window_q;
  logic [6:0]  max_req_q;

  // Per-request working registers
  logic [SLOT_W-1:0]          slot_q, clr_q;
  logic [psra_pkg::SLOT_IN_W-1:0] rem_q, quo_q;
  logic                       k_q;
  logic [TS_W-1:0]            now_q;
  logic [LVL_W-1:0]           lvl_q;
  logic [PROD_W-1:0]          prod_q;
  logic [HEAD_W-1:0]          head_q;
  logic [OCC_W-1:0]           occ_q, i_q, keep_q, occ_new_q;
  logic                       allow_q;

  // Output registers
  logic                       out_valid_q, verdict_q;
  logic [OCC_W-1:0]           occ_out_q;
  logic [psra_pkg::CNT_W-1:0] total_q, allowed_q, throttled_q;

  // Memory ports
  logic              slot_we;
  logic [SLOT_W-1:0] slot_waddr;
  slot_rec_t         slot_wrec, slot_rrec;
  logic [REC_W-1:0]  slot_rdata;
  logic              st_we;
  logic [ST_AW-1:0]  st_waddr, st_raddr;
  logic [TS_W-1:0]   st_wdata, st_rdata;

  // Datapath
  logic [LVL_W-1:0]  cap;
  logic [TS_W-1:0]   wms, elapsed;
  logic [LVL_W+23:0] lvl_sum;
  logic [LVL_W-1:0]  lvl_clip;
  logic              tok_ok, stamp_keep;
  logic [OCC_W-1:0]  lim, occ_clip;
  logic [31:0]       mod_prod;
  logic [psra_pkg::SLOT_IN_W-1:0] mod_rem;
  logic              done_go;

  function automatic logic [HEAD_W-1:0] ring_idx(input logic [HEAD_W-1:0] h,
                                                 input logic [OCC_W-1:0] x);
    logic [SUM_W-1:0] s;
    s = SUM_W'(h) + SUM_W'(x);
    if (s >= SUM_W'(WINDOW_DEPTH)) begin
      s = s - SUM_W'(WINDOW_DEPTH);
    end
    return HEAD_W'(s);
  endfunction

  function automatic logic [ST_AW-1:0] stamp_addr(input logic [SLOT_W-1:0] s,
                                                  input logic [HEAD_W-1:0] idx);
    return ST_AW'(s) * ST_AW'(WINDOW_DEPTH) + ST_AW'(idx);
  endfunction

  assign slot_rrec = slot_rdata;

  // Derive limits from configuration
  assign cap = LVL_W'(32'(burst_q) * 32'(psra_pkg::MS_PER_S));
  assign wms = TS_W'(32'(window_q) * 32'(psra_pkg::MS_PER_S));
  assign lim = (32'(max_req_q) > 32'(WINDOW_DEPTH)) ? OCC_W'(WINDOW_DEPTH)
                                                     : OCC_W'(max_req_q);
  assign occ_clip = (32'(occ_q) > 32'(WINDOW_DEPTH)) ? OCC_W'(WINDOW_DEPTH) : occ_q;

  // Refill, clip and charge
  assign elapsed  = now_q - slot_rrec.last;
  assign lvl_sum  = (LVL_W + 24)'(lvl_q) + (LVL_W + 24)'(prod_q);
  assign lvl_clip = (lvl_sum > (LVL_W + 24)'(cap)) ? cap : LVL_W'(lvl_sum);
  assign tok_ok   = lvl_clip >= LVL_W'(psra_pkg::MS_PER_S);

  // Stamp age test
  assign stamp_keep = (now_q - st_rdata) <= wms;

  // Reduce the slot: quotient by reciprocal multiply, then the remainder
  assign mod_prod = 32'(rem_q) * 32'(MOD_RECIP);
  assign mod_rem  = rem_q - psra_pkg::SLOT_IN_W'(32'(quo_q) * 32'(SLOTS));

  assign done_go = !out_valid_q || out_ready_i;

  // Memory port control
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = slot_q;
    slot_wrec  = '{valid: 1'b1, level: lvl_q, last: now_q, head: head_q,
                   occ: occ_new_q};
    st_we      = 1'b0;
    st_waddr   = stamp_addr(slot_q, ring_idx(head_q, keep_q));
    st_wdata   = st_rdata;
    st_raddr   = stamp_addr(slot_q, ring_idx(head_q, i_q));
    case (state_q)
      S_CLR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_q;
        slot_wrec  = '0;
      end
      S_WCHK: begin
        st_we = stamp_keep;
      end
      S_WADD: begin
        st_we    = keep_q < lim;
        st_wdata = now_q;
      end
      S_DONE: begin
        slot_we = done_go;
      end
      default: begin
      end
    endcase
  end

  psra_ram #(.WIDTH(REC_W), .DEPTH(SLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wrec),
    .raddr_i (slot_q),
    .rdata_o (slot_rdata)
  );

  psra_ram #(.WIDTH(TS_W), .DEPTH(ST_DEPTH)) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // Hold configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_q   <= psra_pkg::BURST_RST;
      refill_q  <= psra_pkg::REFILL_RST;
      window_q  <= psra_pkg::WINDOW_RST;
      max_req_q <= psra_pkg::MAX_REQ_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        psra_pkg::REG_BURST:   burst_q   <= cfg_wdata_i;
        psra_pkg::REG_REFILL:  refill_q  <= cfg_wdata_i;
        psra_pkg::REG_WINDOW:  window_q  <= cfg_wdata_i[11:0];
        psra_pkg::REG_MAX_REQ: max_req_q <= cfg_wdata_i[6:0];
        default: begin
        end
      endcase
    end
  end

  // Sequence each request and hold the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      slot_q      <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      k_q         <= 1'b0;
      now_q       <= '0;
      lvl_q       <= '0;
      prod_q      <= '0;
      head_q      <= '0;
      occ_q       <= '0;
      i_q         <= '0;
      keep_q      <= '0;
      occ_new_q   <= '0;
      allow_q     <= 1'b0;
      out_valid_q <= 1'b0;
      verdict_q   <= 1'b0;
      occ_out_q   <= '0;
      total_q     <= '0;
      allowed_q   <= '0;
      throttled_q <= '0;
    end else begin
      // Drop a taken result unless a new one replaces it
      if (out_valid_q && out_ready_i && !(state_q == S_DONE && done_go)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (32'(clr_q) == SLOTS - 1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            now_q  <= now_ms_i;
            rem_q  <= flow_slot_i;
            k_q    <= 1'b0;
            slot_q <= SLOT_W'(flow_slot_i);
            if (MOD_SERIAL) begin
              state_q <= S_MOD;
            end else begin
              state_q <= S_RD;
            end
          end
        end
        S_MOD: begin
          if (!k_q) begin
            quo_q <= psra_pkg::SLOT_IN_W'(mod_prod >> MOD_SHIFT);
            k_q   <= 1'b1;
          end else begin
            slot_q  <= SLOT_W'(mod_rem);
            state_q <= S_RD;
          end
        end
        S_RD: begin
          state_q <= S_MUL;
        end
        S_MUL: begin
          // Start a fresh slot full, with an empty window
          if (slot_rrec.valid) begin
            lvl_q  <= slot_rrec.level;
            head_q <= slot_rrec.head;
            occ_q  <= slot_rrec.occ;
            prod_q <= {16'd0, elapsed} * {32'd0, refill_q};
          end else begin
            lvl_q  <= cap;
            head_q <= '0;
            occ_q  <= '0;
            prod_q <= '0;
          end
          state_q <= S_BKT;
        end
        S_BKT: begin
          lvl_q  <= tok_ok ? lvl_clip - LVL_W'(psra_pkg::MS_PER_S) : lvl_clip;
          i_q    <= '0;
          keep_q <= '0;
          if (!tok_ok) begin
            allow_q   <= 1'b0;
            occ_new_q <= occ_q;
            state_q   <= S_DONE;
          end else begin
            occ_q <= occ_clip;
            if (occ_clip == '0) begin
              state_q <= S_WADD;
            end else begin
              state_q <= S_WRD;
            end
          end
        end
        S_WRD: begin
          state_q <= S_WCHK;
        end
        S_WCHK: begin
          // Compact surviving stamps toward the head
          if (stamp_keep) begin
            keep_q <= keep_q + 1'b1;
          end
          i_q <= i_q + 1'b1;
          if (i_q + 1'b1 == occ_q) begin
            state_q <= S_WADD;
          end else begin
            state_q <= S_WRD;
          end
        end
        S_WADD: begin
          allow_q   <= keep_q < lim;
          occ_new_q <= (keep_q < lim) ? keep_q + 1'b1 : keep_q;
          state_q   <= S_DONE;
        end
        S_DONE: begin
          if (done_go) begin
            out_valid_q <= 1'b1;
            verdict_q   <= !allow_q;
            occ_out_q   <= occ_new_q;
            total_q     <= total_q + 1'b1;
            if (allow_q) begin
              allowed_q <= allowed_q + 1'b1;
            end else begin
              throttled_q <= throttled_q + 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o        = state_q == S_IDLE;
  assign out_valid_o       = out_valid_q;
  assign verdict_o         = verdict_q;
  assign window_fill_o     = psra_pkg::FILL_W'(occ_out_q);
  assign total_count_o     = total_q;
  assign allowed_count_o   = allowed_q;
  assign throttled_count_o = throttled_q;

  // Counters stay consistent
  a_count_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> total_count_o == allowed_count_o + throttled_count_o)
    else $error("request counters disagree");

  // An allowed request leaves its own stamp behind
  a_allow_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !verdict_o |-> occ_out_q != '0)
    else $error("allowed request with empty window");

  // Window never holds more than its depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(occ_out_q) <= WINDOW_DEPTH)
    else $error("window fill beyond depth");

  // A pending result is not overwritten
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(total_count_o))
    else $error("pending result lost");

endmodule

`default_nettype wire

@@ sv/psra_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module psra_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

@@ verif/per_source_rate_admission_unit_tb.sv @@
`timescale 1ns / 1ps

module per_source_rate_admission_unit_tb;

  localparam int unsigned NSLOT      = 1024;
  localparam int unsigned WDEPTH     = 64;
  localparam int unsigned STALL_MAX  = 20000;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned PHASES     = 8;
  localparam int unsigned PHASE_LEN  = 117;
  localparam int unsigned PEND_DEPTH = 16;
  localparam int unsigned ROW_MAX    = 32;

  typedef enum logic { ROW_REQ, ROW_CFG } row_kind_e;

  typedef struct {
    logic                        verdict;
    logic [psra_pkg::FILL_W-1:0] fill;
    logic [psra_pkg::CNT_W-1:0]  total;
    logic [psra_pkg::CNT_W-1:0]  allowed;
    logic [psra_pkg::CNT_W-1:0]  throttled;
  } verdict_t;

  typedef struct {
    row_kind_e                   kind;
    logic [9:0]                  slot;
    logic [31:0]                 now;
    bit                          typed;
    logic                        verdict;
    logic [psra_pkg::FILL_W-1:0] fill;
    logic [15:0]                 burst;
    logic [15:0]                 refill;
    logic [11:0]                 win_s;
    logic [6:0]                  max_req;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [psra_pkg::SLOT_IN_W-1:0] flow_slot_i = '0;
  logic [psra_pkg::STAMP_W-1:0] now_ms_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic verdict_o;
  logic [psra_pkg::FILL_W-1:0] window_fill_o;
  logic [psra_pkg::CNT_W-1:0] total_count_o, allowed_count_o, throttled_count_o;
  logic cfg_we_i = 1'b0;
  logic [psra_pkg::CFG_IDX_W-1:0] cfg_addr_i = psra_pkg::REG_BURST;
  logic [psra_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;

  per_source_rate_admission_unit u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .flow_slot_i, .now_ms_i,
    .out_valid_o, .out_ready_i, .verdict_o, .window_fill_o, .total_count_o,
    .allowed_count_o, .throttled_count_o, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the policer state
  logic [15:0] sh_burst = psra_pkg::BURST_RST;
  logic [15:0] sh_refill = psra_pkg::REFILL_RST;
  logic [11:0] sh_win_s = psra_pkg::WINDOW_RST;
  logic [6:0]  sh_max = psra_pkg::MAX_REQ_RST;
  bit          seen_slot [NSLOT];
  logic [31:0] bucket_lvl [NSLOT];
  logic [31:0] last_ms [NSLOT];
  logic [31:0] stamp_mem [NSLOT][WDEPTH];
  int unsigned win_head [NSLOT];
  int unsigned win_occ [NSLOT];
  logic [31:0] cnt_total = '0, cnt_allowed = '0, cnt_throttled = '0;

  // Predictions waiting for their result transaction
  verdict_t pend_mem [PEND_DEPTH];
  int unsigned pend_wr = 0;
  int unsigned pend_rd = 0;

  // Directed stimulus table
  row_t rows [ROW_MAX];
  int unsigned row_n = 0;

  int unsigned err_cnt = 0;
  bit calm = 1'b0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned idle_cnt = 0;

  // Refill and charge the bucket, then run the sliding window
  function automatic verdict_t police(logic [9:0] slot, logic [31:0] now);
    verdict_t r;
    longint unsigned lvl, cap;
    logic [31:0] elapsed, wms, st;
    int unsigned keep, lim, hd, occ;
    bit ok;
    if (!seen_slot[slot]) begin
      seen_slot[slot] = 1'b1;
      bucket_lvl[slot] = sh_burst * psra_pkg::MS_PER_S;
      last_ms[slot] = now;
      win_head[slot] = 0;
      win_occ[slot] = 0;
    end
    cap = longint'(sh_burst) * psra_pkg::MS_PER_S;
    elapsed = now - last_ms[slot];
    lvl = longint'(bucket_lvl[slot]) + longint'(elapsed) * longint'(sh_refill);
    if (lvl > cap) lvl = cap;
    last_ms[slot] = now;
    ok = lvl >= psra_pkg::MS_PER_S;
    if (ok) lvl -= psra_pkg::MS_PER_S;
    bucket_lvl[slot] = lvl[31:0];
    if (ok) begin
      wms = sh_win_s * psra_pkg::MS_PER_S;
      hd = win_head[slot] % WDEPTH;
      occ = (win_occ[slot] > WDEPTH) ? WDEPTH : win_occ[slot];
      keep = 0;
      // compact survivors toward the head, keeping order
      for (int i = 0; i < occ; i++) begin
        st = stamp_mem[slot][(hd + i) % WDEPTH];
        if (now - st <= wms) begin
          stamp_mem[slot][(hd + keep) % WDEPTH] = st;
          keep++;
        end
      end
      lim = (sh_max > WDEPTH) ? WDEPTH : sh_max;
      win_head[slot] = hd;
      if (keep < lim) begin
        stamp_mem[slot][(hd + keep) % WDEPTH] = now;
        win_occ[slot] = keep + 1;
      end else begin
        win_occ[slot] = keep;
        ok = 1'b0;
      end
    end
    cnt_total++;
    if (ok) cnt_allowed++;
    else cnt_throttled++;
    r.verdict = !ok;
    r.fill = win_occ[slot][psra_pkg::FILL_W-1:0];
    r.total = cnt_total;
    r.allowed = cnt_allowed;
    r.throttled = cnt_throttled;
    return r;
  endfunction

  // Append one row to the directed table
  task automatic add_row(row_t r);
    rows[row_n] = r;
    row_n++;
  endtask

  // Offer one request; hold it until accepted, then record the prediction
  task automatic send_req(logic [9:0] slot, logic [31:0] now, bit typed,
                          logic v, logic [psra_pkg::FILL_W-1:0] f);
    verdict_t e;
    if (!calm && $urandom_range(99) < 31) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 31);
    end
    in_valid_i <= 1'b1;
    flow_slot_i <= slot;
    now_ms_i <= now;
    do @(posedge clk_i); while (!in_ready_o);
    e = police(slot, now);
    if (typed && (e.verdict !== v || e.fill !== f)) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("slot %0d: predicted verdict %0b fill %0d, table says %0b %0d",
                 slot, e.verdict, e.fill, v, f);
      e.verdict = v;
      e.fill = f;
    end
    pend_mem[pend_wr % PEND_DEPTH] = e;
    pend_wr++;
  endtask

  // Drain, then write all four registers back to back
  task automatic write_regs(logic [15:0] b, logic [15:0] r, logic [11:0] w,
                            logic [6:0] m);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pend_wr != pend_rd);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_addr_i <= psra_pkg::REG_BURST; cfg_wdata_i <= b;
    @(posedge clk_i);
    cfg_addr_i <= psra_pkg::REG_REFILL; cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_addr_i <= psra_pkg::REG_WINDOW; cfg_wdata_i <= 16'(w);
    @(posedge clk_i);
    cfg_addr_i <= psra_pkg::REG_MAX_REQ; cfg_wdata_i <= 16'(m);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sh_burst = b; sh_refill = r; sh_win_s = w; sh_max = m;
  endtask

  // Check each returned verdict against the oldest prediction
  always @(posedge clk_i) begin
    verdict_t e;
    if (out_valid_o && out_ready_i) begin
      if (pend_wr == pend_rd) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result transaction");
      end else begin
        e = pend_mem[pend_rd % PEND_DEPTH];
        pend_rd++;
        if (verdict_o !== e.verdict || window_fill_o !== e.fill ||
            total_count_o !== e.total || allowed_count_o !== e.allowed ||
            throttled_count_o !== e.throttled) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch exp v%0b f%0d t%0d a%0d h%0d got v%0b f%0d t%0d a%0d h%0d",
                     e.verdict, e.fill, e.total, e.allowed, e.throttled,
                     verdict_o, window_fill_o, total_count_o, allowed_count_o,
                     throttled_count_o);
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off
  always @(posedge clk_i) begin
    if (hold_go && !hold_done && hold_cnt == 0) begin
      hold_cnt <= HOLD_LEN;
      hold_done <= 1'b1;
      out_ready_i <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= 31);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= STALL_MAX) begin
      $display("per_source_rate_admission_unit_tb: errors");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    row_t rw;
    logic [9:0] pool [4];
    logic [31:0] tnow;
    int unsigned step_max;

    // Directed table: first use, wrap, time going back, bucket drain, limits
    add_row('{ROW_REQ, 10'd0, 32'd1000, 1, 1'b0, 7'd1, 0, 0, 0, 0});
    add_row('{ROW_REQ, 10'd1023, 32'hFFFF_FFFF, 1, 1'b0, 7'd1, 0, 0, 0, 0});
    add_row('{ROW_REQ, 10'd1023, 32'd0, 1, 1'b0, 7'd2, 0, 0, 0, 0});
    add_row('{ROW_REQ, 10'd0, 32'd500, 1, 1'b0, 7'd1, 0, 0, 0, 0});
    for (int i = 0; i < 11; i++)
      add_row('{ROW_REQ, 10'd5, 32'd2000, 1, (i >= 10), (i < 10) ? 7'(i + 1) : 7'd10,
                0, 0, 0, 0});
    add_row('{ROW_CFG, 0, 0, 0, 0, 0, 16'd0, 16'd5, 12'd60, 7'd60});
    add_row('{ROW_REQ, 10'd7, 32'd3000, 1, 1'b1, 7'd0, 0, 0, 0, 0});
    add_row('{ROW_CFG, 0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 12'd1, 7'd0});
    add_row('{ROW_REQ, 10'd8, 32'd4000, 1, 1'b1, 7'd0, 0, 0, 0, 0});
    add_row('{ROW_REQ, 10'd8, 32'd4000, 1, 1'b1, 7'd0, 0, 0, 0, 0});
    add_row('{ROW_CFG, 0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 12'd3600, 7'd127});
    add_row('{ROW_REQ, 10'd9, 32'd100, 1, 1'b0, 7'd1, 0, 0, 0, 0});
    add_row('{ROW_REQ, 10'd512, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0});
    add_row('{ROW_REQ, 10'd9, 32'd3_600_200, 0, 0, 0, 0, 0, 0, 0});

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < row_n; i++) begin
      rw = rows[i];
      if (rw.kind == ROW_CFG) write_regs(rw.burst, rw.refill, rw.win_s, rw.max_req);
      else send_req(rw.slot, rw.now, rw.typed, rw.verdict, rw.fill);
    end

    // Random phases, each with its own register setting
    tnow = $urandom;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: write_regs(16'hFFFF, 16'hFFFF, 12'd3600, 7'd64);
        1: write_regs(16'd1, 16'd0, 12'd1, 7'd1);
        2: write_regs(16'd3, 16'd2000, 12'd2, 7'd5);
        default: write_regs(16'($urandom_range(0, 65535)) >> $urandom_range(0, 15),
                            16'($urandom_range(0, 65535)) >> $urandom_range(0, 15),
                            12'($urandom_range(1, 3600)) >> $urandom_range(0, 11),
                            7'($urandom_range(0, 127)));
      endcase
      calm = (p == 2);
      if (p == 3) hold_go = 1'b1;
      step_max = (sh_win_s * psra_pkg::MS_PER_S) / 20 + 1;
      foreach (pool[k]) pool[k] = 10'($urandom_range(0, 1023));
      for (int n = 0; n < PHASE_LEN; n++) begin
        if ($urandom_range(99) < 4) tnow = $urandom;
        else tnow += $urandom_range(0, step_max);
        if ($urandom_range(99) < 10)
          send_req(10'($urandom_range(0, 1023)), tnow, 0, 0, 0);
        else
          send_req(pool[$urandom_range(0, 3)], tnow, 0, 0, 0);
      end
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    do @(posedge clk_i); while (pend_wr != pend_rd);
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0 && pend_wr == pend_rd) begin
      $display("per_source_rate_admission_unit_tb: clean");
    end else begin
      $display("per_source_rate_admission_unit_tb: errors");
    end
    $finish;
  end

endmodule
